>>> rtl/cges_pkg.sv
`default_nettype none

package cges_pkg;

    localparam int DEF_NUM_BODIES = 8;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int GRAV_CONST    = 25;
    localparam int CENTRAL_MASS  = 4;
    localparam int CENTRE_X_INIT = 60;
    localparam int CENTRE_Y_INIT = 25;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 3;
    localparam int D_W       = 33;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int S_W       = 66;
    localparam int ROOT_W    = 34;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int R2_W      = 2 * ROOT_W;
    localparam int R3_W      = 3 * ROOT_W;
    localparam int DIV_STEPS = 35;
    localparam int QUO_W     = DIV_STEPS;
    localparam int MAG_W     = 34;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 6;

    localparam logic [MAG_W-1:0] ACC_LIM = MAG_W'(1) << 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X  = 2'd0,
        CFG_CENTRE_Y  = 2'd1,
        CFG_GRAV_MASS = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        logic               operation;
        logic [IDX_W-1:0]   body_index;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               at_centre;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_body;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_UXUX,
        MUL_UYUY,
        MUL_RR,
        MUL_R3LO,
        MUL_R3HI,
        MUL_GX,
        MUL_GY
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_S_SET,
        ACC_S_ADD,
        ACC_R2_SET,
        ACC_R3_SET,
        ACC_R3_ADD,
        ACC_NX_SET,
        ACC_NY_SET
    } t_acc_sel;

    typedef struct packed {
        logic     capture;
        logic     diff;
        t_mul_sel mul_sel;
        t_acc_sel acc_sel;
        logic     set_centre;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     vel;
        logic     pos;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic new_is_step;
        logic new_in_range;
        logic s_zero;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_ACC,
        ST_CHK,
        ST_SQRT,
        ST_R2,
        ST_R2_ACC,
        ST_R3_LO,
        ST_R3_HI,
        ST_R3_ACC,
        ST_G_X,
        ST_G_Y,
        ST_G_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_VEL,
        ST_POS,
        ST_DONE
    } t_state;

    function automatic logic signed [31:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v > SUM_W'(signed'(32'sh7fff_ffff))) begin
            res = 32'sh7fff_ffff;
        end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
        return (v > SUM_W'(signed'(32'sh7fff_ffff))) || (v < SUM_W'(signed'(32'sh8000_0000)));
    endfunction

endpackage

`default_nettype wire

>>> rtl/cges_in_if.sv
`default_nettype none

interface cges_in_if import cges_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/cges_out_if.sv
`default_nettype none

interface cges_out_if import cges_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/cges_mem.sv
`default_nettype none

module cges_mem import cges_pkg::*; #(
    parameter int NUM_BODIES = DEF_NUM_BODIES,
    parameter int AW         = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_body         i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_body              o_rdata
);

    t_body                 r_mem [NUM_BODIES];
    logic [NUM_BODIES-1:0] r_valid;
    t_body                 r_rdata;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

>>> rtl/cges_dp.sv
`default_nettype none

module cges_dp import cges_pkg::*; #(
    parameter int NUM_BODIES = DEF_NUM_BODIES,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int AW         = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_item             i_in_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_waddr,
    output t_body                     o_mem_wdata,
    output logic [AW-1:0]             o_mem_raddr,
    input  wire t_body                i_mem_rdata,
    output t_out_item                 o_out_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready
);

    localparam int NW = 65 + 2 * FRAC_BITS;
    localparam int CW = R3_W + DIV_STEPS;

    logic [31:0] r_centre_x;
    logic [31:0] r_centre_y;
    logic [31:0] r_gm;

    logic             r_is_step;
    logic             r_in_range;
    logic [IDX_W-1:0] r_idx;
    t_body            r_ld;
    logic             r_centre;
    logic             r_sat;

    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic               r_nx_neg, r_ny_neg;
    logic [D_W-1:0]     r_ux, r_uy;
    logic [PROD_W-1:0]  r_prod;
    logic [S_W-1:0]     r_s;
    logic [PROD_W-1:0]  r_sq_src;
    logic [ROOT_W:0]    r_sq_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [R2_W-1:0]    r_r2;
    logic [R3_W-1:0]    r_r3;
    logic [NW-1:0]      r_nx, r_ny;
    logic [CW-2:0]      r_dsh;
    logic [NW-1:0]      r_remx, r_remy;
    logic [QUO_W-1:0]   r_qx, r_qy;
    logic               r_ovfx, r_ovfy;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     prod;
    logic signed [D_W-1:0] dx, dy;
    logic [ROOT_W+2:0]     sq_cur, sq_trial;
    logic                  sq_ge;
    logic                  gex, gey;
    logic [MAG_W-1:0]      mag_x, mag_y;
    logic signed [SUM_W-1:0] ax, ay, vsum_x, vsum_y, psum_x, psum_y;
    t_body                 new_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= 32'(CENTRE_X_INIT) << FRAC_BITS;
            r_centre_y <= 32'(CENTRE_Y_INIT) << FRAC_BITS;
            r_gm       <= 32'(GRAV_CONST * CENTRAL_MASS) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_CENTRE_X:  r_centre_x <= i_cfg_data;
                CFG_CENTRE_Y:  r_centre_y <= i_cfg_data;
                CFG_GRAV_MASS: r_gm       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_UXUX: begin mul_a = MUL_W'(r_ux); mul_b = MUL_W'(r_ux); end
            MUL_UYUY: begin mul_a = MUL_W'(r_uy); mul_b = MUL_W'(r_uy); end
            MUL_RR:   begin mul_a = r_root; mul_b = r_root; end
            MUL_R3LO: begin mul_a = r_r2[MUL_W-1:0]; mul_b = r_root; end
            MUL_R3HI: begin mul_a = r_r2[R2_W-1:MUL_W]; mul_b = r_root; end
            MUL_GX:   begin mul_a = MUL_W'(r_gm); mul_b = MUL_W'(r_ux); end
            MUL_GY:   begin mul_a = MUL_W'(r_gm); mul_b = MUL_W'(r_uy); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign dx = $signed({r_centre_x[31], r_centre_x})
              - $signed({i_mem_rdata.pos_x[31], i_mem_rdata.pos_x});
    assign dy = $signed({r_centre_y[31], r_centre_y})
              - $signed({i_mem_rdata.pos_y[31], i_mem_rdata.pos_y});

    assign sq_cur   = {r_sq_rem, r_sq_src[PROD_W-1:PROD_W-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_cur >= sq_trial;

    assign gex = CW'(r_remx) >= {1'b0, r_dsh};
    assign gey = CW'(r_remy) >= {1'b0, r_dsh};

    assign mag_x = (r_ovfx || (r_qx > QUO_W'(ACC_LIM))) ? ACC_LIM : r_qx[MAG_W-1:0];
    assign mag_y = (r_ovfy || (r_qy > QUO_W'(ACC_LIM))) ? ACC_LIM : r_qy[MAG_W-1:0];

    always_comb begin
        if (r_centre) begin
            ax = '0;
            ay = '0;
        end else begin
            ax = r_nx_neg ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x});
            ay = r_ny_neg ? -$signed({2'b00, mag_y}) : $signed({2'b00, mag_y});
        end
    end

    assign vsum_x = SUM_W'(r_vx) + ax;
    assign vsum_y = SUM_W'(r_vy) + ay;
    assign psum_x = SUM_W'(r_px) + SUM_W'(r_vx);
    assign psum_y = SUM_W'(r_py) + SUM_W'(r_vy);

    always_ff @(posedge i_clk) begin
        r_prod <= prod;

        if (i_cmd.capture) begin
            r_is_step  <= i_in_item.operation;
            r_in_range <= int'(i_in_item.body_index) < NUM_BODIES;
            r_idx      <= i_in_item.body_index;
            r_ld       <= '{i_in_item.load_pos_x, i_in_item.load_pos_y,
                            i_in_item.load_vel_x, i_in_item.load_vel_y};
            r_centre   <= 1'b0;
            r_sat      <= 1'b0;
        end

        if (i_cmd.diff) begin
            r_px     <= i_mem_rdata.pos_x;
            r_py     <= i_mem_rdata.pos_y;
            r_vx     <= i_mem_rdata.vel_x;
            r_vy     <= i_mem_rdata.vel_y;
            r_nx_neg <= dx[D_W-1];
            r_ny_neg <= dy[D_W-1];
            r_ux     <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
            r_uy     <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
        end

        case (i_cmd.acc_sel)
            ACC_S_SET:  r_s  <= r_prod[S_W-1:0];
            ACC_S_ADD:  r_s  <= r_s + r_prod[S_W-1:0];
            ACC_R2_SET: r_r2 <= r_prod;
            ACC_R3_SET: r_r3 <= R3_W'(r_prod);
            ACC_R3_ADD: r_r3 <= r_r3 + (R3_W'(r_prod) << MUL_W);
            ACC_NX_SET: r_nx <= NW'(r_prod) << (2 * FRAC_BITS);
            ACC_NY_SET: r_ny <= NW'(r_prod) << (2 * FRAC_BITS);
            default: ;
        endcase

        if (i_cmd.set_centre) begin
            r_centre <= 1'b1;
        end

        if (i_cmd.sqrt_init) begin
            r_sq_src <= PROD_W'(r_s);
            r_sq_rem <= '0;
            r_root   <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_src <= r_sq_src << 2;
            r_sq_rem <= sq_ge ? (ROOT_W+1)'(sq_cur - sq_trial) : (ROOT_W+1)'(sq_cur);
            r_root   <= {r_root[ROOT_W-2:0], sq_ge};
        end

        if (i_cmd.div_init) begin
            r_dsh  <= {r_r3, (DIV_STEPS-1)'(0)};
            r_remx <= r_nx;
            r_remy <= r_ny;
            r_ovfx <= CW'(r_nx) >= {r_r3, DIV_STEPS'(0)};
            r_ovfy <= CW'(r_ny) >= {r_r3, DIV_STEPS'(0)};
            r_qx   <= '0;
            r_qy   <= '0;
        end else if (i_cmd.div_step) begin
            r_dsh  <= r_dsh >> 1;
            r_remx <= gex ? r_remx - NW'(r_dsh) : r_remx;
            r_remy <= gey ? r_remy - NW'(r_dsh) : r_remy;
            r_qx   <= {r_qx[QUO_W-2:0], gex};
            r_qy   <= {r_qy[QUO_W-2:0], gey};
        end

        if (i_cmd.vel) begin
            r_vx  <= sat_val(vsum_x);
            r_vy  <= sat_val(vsum_y);
            r_sat <= r_sat | sat_hit(vsum_x) | sat_hit(vsum_y);
        end

        if (i_cmd.pos) begin
            r_px  <= sat_val(psum_x);
            r_py  <= sat_val(psum_y);
            r_sat <= r_sat | sat_hit(psum_x) | sat_hit(psum_y);
        end

        if (i_cmd.out_load) begin
            r_out.out_index <= r_idx;
            r_out.new_pos_x <= r_in_range ? new_body.pos_x : '0;
            r_out.new_pos_y <= r_in_range ? new_body.pos_y : '0;
            r_out.new_vel_x <= r_in_range ? new_body.vel_x : '0;
            r_out.new_vel_y <= r_in_range ? new_body.vel_y : '0;
            r_out.at_centre <= r_in_range && r_is_step && r_centre;
            r_out.saturated <= r_in_range && r_is_step && r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign new_body = r_is_step ? t_body'{r_px, r_py, r_vx, r_vy} : r_ld;

    assign o_mem_we    = i_cmd.out_load && r_in_range;
    assign o_mem_waddr = AW'(r_idx);
    assign o_mem_wdata = new_body;
    assign o_mem_raddr = AW'(i_in_item.body_index);

    assign o_stat.new_is_step  = i_in_item.operation == OP_STEP;
    assign o_stat.new_in_range = int'(i_in_item.body_index) < NUM_BODIES;
    assign o_stat.s_zero       = r_s == '0;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/cges_ctrl.sv
`default_nettype none

module cges_ctrl import cges_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_mem_re
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_mem_re   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_mem_re      = 1'b1;
                    n_state = (i_stat.new_is_step && i_stat.new_in_range) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_SQ_X;
            end
            ST_SQ_X: begin
                o_cmd.mul_sel = MUL_UXUX;
                n_state       = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_cmd.mul_sel = MUL_UYUY;
                o_cmd.acc_sel = ACC_S_SET;
                n_state       = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_cmd.acc_sel = ACC_S_ADD;
                n_state       = ST_CHK;
            end
            ST_CHK: begin
                if (i_stat.s_zero) begin
                    o_cmd.set_centre = 1'b1;
                    n_state          = ST_VEL;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt           = CNT_W'(SQ_STEPS - 1);
                    n_state         = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_R2;
                end
            end
            ST_R2: begin
                o_cmd.mul_sel = MUL_RR;
                n_state       = ST_R2_ACC;
            end
            ST_R2_ACC: begin
                o_cmd.acc_sel = ACC_R2_SET;
                n_state       = ST_R3_LO;
            end
            ST_R3_LO: begin
                o_cmd.mul_sel = MUL_R3LO;
                n_state       = ST_R3_HI;
            end
            ST_R3_HI: begin
                o_cmd.mul_sel = MUL_R3HI;
                o_cmd.acc_sel = ACC_R3_SET;
                n_state       = ST_R3_ACC;
            end
            ST_R3_ACC: begin
                o_cmd.acc_sel = ACC_R3_ADD;
                n_state       = ST_G_X;
            end
            ST_G_X: begin
                o_cmd.mul_sel = MUL_GX;
                n_state       = ST_G_Y;
            end
            ST_G_Y: begin
                o_cmd.mul_sel = MUL_GY;
                o_cmd.acc_sel = ACC_NX_SET;
                n_state       = ST_G_ACC;
            end
            ST_G_ACC: begin
                o_cmd.acc_sel = ACC_NY_SET;
                n_state       = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(DIV_STEPS - 1);
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_VEL;
                end
            end
            ST_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = ST_POS;
            end
            ST_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/central_gravity_euler_step.sv
// Sequence: a step item runs read, squares, bit-serial square root, cube, GM
// products, bit-serial division, velocity, position; a zero-distance step skips
// from the squares to velocity; a load or out-of-table item goes to output.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; clears the body table valid bits, the
// controller, the output register and loads the default centre and GM.
`default_nettype none

module central_gravity_euler_step import cges_pkg::*; #(
    parameter int NUM_BODIES = DEF_NUM_BODIES,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cges_in_if.sink                   i_in,
    cges_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      mem_re;
    logic      mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_body     mem_wdata, mem_rdata;

    cges_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_mem_re   (mem_re)
    );

    cges_dp #(
        .NUM_BODIES (NUM_BODIES),
        .FRAC_BITS  (FRAC_BITS),
        .AW         (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_out_item  (o_out.payload),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready)
    );

    cges_mem #(
        .NUM_BODIES (NUM_BODIES),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready = in_ready;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result appeared without an item in work");

    a_out_of_table_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (int'(o_out.payload.out_index) >= NUM_BODIES)) |->
        (o_out.payload.new_pos_x == '0 && o_out.payload.new_pos_y == '0 &&
         o_out.payload.new_vel_x == '0 && o_out.payload.new_vel_y == '0 &&
         !o_out.payload.at_centre && !o_out.payload.saturated))
        else $error("out-of-table result carries state");

endmodule

`default_nettype wire
